>>> rtl/core/wts_pkg.sv
// shared types and constants of the weighted table sampler
package wts_pkg;

  localparam int OP_W      = 3;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 4;
  localparam int FIELD_W   = 16;
  localparam int CHOICE_W  = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int EXT_W     = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_WR_NOTE     = 3'd0,
    OP_WR_RHYTHM   = 3'd1,
    OP_SET_ROW     = 3'd2,
    OP_DRAW_NOTE   = 3'd3,
    OP_DRAW_RHYTHM = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATE_COUNT  = 2'd0,
    REG_NOTE_COUNT   = 2'd1,
    REG_RHYTHM_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_HOLD = 2'd2
  } draw_state_t;

  typedef struct packed {
    logic               start;
    logic               rhythm;
    logic [COUNT_W-1:0] cols;
    logic [FIELD_W-1:0] rnd;
  } draw_cmd_t;

  typedef struct packed {
    logic               en;
    logic [COUNT_W-1:0] col;
  } rd_req_t;

  typedef struct packed {
    logic                valid;
    logic [CHOICE_W-1:0] choice;
    logic                from_rhythm;
    logic                fallback;
  } draw_res_t;

endpackage

>>> rtl/core/wts_weight_mem.sv
// one weight table: single write port, registered read port
module wts_weight_mem #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/wts_draw_engine.sv
// draw sequencer: walks one table row and accumulates the running sum
module wts_draw_engine #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wts_pkg::draw_cmd_t     cmd,
  input  logic                   out_free,
  input  logic [WEIGHT_BITS-1:0] rd_data,
  output wts_pkg::rd_req_t       rd,
  output wts_pkg::draw_res_t     res,
  output logic                   busy
);

  localparam int SUM_W = (WEIGHT_BITS + wts_pkg::COUNT_W > wts_pkg::FIELD_W)
                         ? WEIGHT_BITS + wts_pkg::COUNT_W : wts_pkg::FIELD_W + 1;

  wts_pkg::draw_state_t state, state_next;

  logic [wts_pkg::COUNT_W-1:0] iss;
  logic [wts_pkg::COUNT_W-1:0] chk;
  logic [wts_pkg::COUNT_W-1:0] cols;
  logic [wts_pkg::COUNT_W-1:0] res_idx;
  logic                        pending;
  logic [SUM_W-1:0]            sum;
  logic [wts_pkg::FIELD_W-1:0] rnd;
  logic                        rhythm;
  logic                        res_fallback;

  logic [SUM_W-1:0] sum_new;
  logic             issue;
  logic             hit;
  logic             exhausted;

  assign issue     = (state == wts_pkg::ST_WALK) && (iss < cols);
  assign sum_new   = sum + SUM_W'(rd_data);
  assign hit       = (state == wts_pkg::ST_WALK) && pending && (SUM_W'(rnd) < sum_new);
  assign exhausted = (state == wts_pkg::ST_WALK) && !pending && (iss == cols);

  always_comb begin
    state_next = state;
    case (state)
      wts_pkg::ST_IDLE: begin
        if (cmd.start) begin
          state_next = wts_pkg::ST_WALK;
        end
      end
      wts_pkg::ST_WALK: begin
        if (hit || exhausted) begin
          state_next = wts_pkg::ST_HOLD;
        end
      end
      wts_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = wts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd.en           = issue;
    rd.col          = iss;
    res.valid       = (state == wts_pkg::ST_HOLD) && out_free;
    res.choice      = res_idx[wts_pkg::CHOICE_W-1:0];
    res.from_rhythm = rhythm;
    res.fallback    = res_fallback;
    busy            = (state != wts_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wts_pkg::ST_IDLE && cmd.start) begin
      iss     <= '0;
      chk     <= '0;
      pending <= 1'b0;
      sum     <= '0;
      rnd     <= cmd.rnd;
      cols    <= cmd.cols;
      rhythm  <= cmd.rhythm;
    end else if (state == wts_pkg::ST_WALK) begin
      pending <= issue;
      iss     <= iss + wts_pkg::COUNT_W'(issue);
      if (pending) begin
        sum <= sum_new;
        chk <= chk + 1'b1;
      end
      if (hit) begin
        res_idx      <= chk;
        res_fallback <= 1'b0;
      end else if (exhausted) begin
        res_idx      <= '0;
        res_fallback <= 1'b1;
      end
    end
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == wts_pkg::ST_WALK) |-> (iss <= cols))
    else $error("read index ran past the row length");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (state == wts_pkg::ST_WALK) |-> (chk + wts_pkg::COUNT_W'(pending) == iss))
    else $error("returned read data out of step with issued reads");

  a_hit_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == wts_pkg::ST_HOLD && !res_fallback) |-> (res_idx < cols))
    else $error("selected index outside the row in use");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    (state == wts_pkg::ST_HOLD && !out_free) |=>
      (state == wts_pkg::ST_HOLD && $stable(res_idx) && $stable(res_fallback)))
    else $error("pending result changed while waiting for the output");

endmodule

>>> rtl/core/weighted_table_sampler_unit.sv
// weighted table sampler top level: decode, config registers, tables, result register
// latency: weight write and set row take effect at the accepting edge, no result beat
// draw beat: walk to the hit index (whole row on fallback), hold state, output register
// throughput: writes and set row one per cycle while no draw runs; a draw holds the input
//   off through any output stall until its result is taken, reading one row entry per cycle
// reset: clears current row, counts to 16 and the output beat; tables undefined until written
module weighted_table_sampler_unit #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_CHOICES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [39:0]                     s_tdata,   // row, column, weight, random_value
  input  logic [wts_pkg::OP_W-1:0]        s_tuser,   // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // choice, zero fill
  output logic [1:0]                      m_tuser,   // from_rhythm, fallback
  input  logic                            cfg_we,
  input  logic [wts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wts_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = (MAX_CHOICES > 1) ? $clog2(MAX_CHOICES) : 1;
  localparam int ADDR_W = ROW_AW + COL_AW;

  logic [wts_pkg::COUNT_W-1:0] state_count;
  logic [wts_pkg::COUNT_W-1:0] note_count;
  logic [wts_pkg::COUNT_W-1:0] rhythm_count;
  logic [wts_pkg::ROW_W-1:0]   current_row;
  logic                        draw_rhythm;

  wts_pkg::op_t                op;
  logic [wts_pkg::ROW_W-1:0]   in_row;
  logic [wts_pkg::COL_W-1:0]   in_col;
  logic [wts_pkg::FIELD_W-1:0] in_weight;
  logic [wts_pkg::FIELD_W-1:0] in_rnd;
  logic                        in_acc;

  logic                        row_ok;
  logic                        note_col_ok;
  logic                        rhythm_col_ok;
  logic                        cur_ok;
  logic [wts_pkg::COUNT_W-1:0] note_cols;
  logic [wts_pkg::COUNT_W-1:0] rhythm_cols;
  logic                        note_we;
  logic                        rhythm_we;
  logic                        set_row;
  logic                        draw_start;
  logic                        draw_is_rhythm;

  logic [wts_pkg::EXT_W-1:0]   row_ext;
  logic [wts_pkg::EXT_W-1:0]   col_ext;
  logic [wts_pkg::EXT_W-1:0]   cur_ext;
  logic [wts_pkg::EXT_W-1:0]   rcol_ext;
  logic [31:0]                 weight_ext;
  logic [ADDR_W-1:0]           waddr;
  logic [ADDR_W-1:0]           raddr;
  logic [WEIGHT_BITS-1:0]      wdata;
  logic [WEIGHT_BITS-1:0]      note_q;
  logic [WEIGHT_BITS-1:0]      rhythm_q;
  logic [WEIGHT_BITS-1:0]      rd_data;

  wts_pkg::draw_cmd_t cmd;
  wts_pkg::rd_req_t   rd;
  wts_pkg::draw_res_t res;
  logic               busy;
  logic               out_free;

  logic [wts_pkg::CHOICE_W-1:0] out_choice;
  logic                         out_rhythm;
  logic                         out_fallback;

  assign op        = wts_pkg::op_t'(s_tuser);
  assign in_row    = s_tdata[3:0];
  assign in_col    = s_tdata[7:4];
  assign in_weight = s_tdata[23:8];
  assign in_rnd    = s_tdata[39:24];

  assign s_tready = !busy;
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign row_ok        = ({1'b0, in_row} < state_count) && (int'(in_row) < MAX_ROWS);
  assign note_col_ok   = ({1'b0, in_col} < note_count) && (int'(in_col) < MAX_CHOICES);
  assign rhythm_col_ok = ({1'b0, in_col} < rhythm_count) && (int'(in_col) < MAX_CHOICES);
  assign cur_ok        = ({1'b0, current_row} < state_count) && (int'(current_row) < MAX_ROWS);
  assign note_cols     = (int'(note_count) < MAX_CHOICES) ? note_count
                                                          : wts_pkg::COUNT_W'(MAX_CHOICES);
  assign rhythm_cols   = (int'(rhythm_count) < MAX_CHOICES) ? rhythm_count
                                                            : wts_pkg::COUNT_W'(MAX_CHOICES);

  always_comb begin
    note_we        = 1'b0;
    rhythm_we      = 1'b0;
    set_row        = 1'b0;
    draw_start     = 1'b0;
    draw_is_rhythm = 1'b0;
    case (op)
      wts_pkg::OP_WR_NOTE:     note_we   = in_acc && row_ok && note_col_ok;
      wts_pkg::OP_WR_RHYTHM:   rhythm_we = in_acc && row_ok && rhythm_col_ok;
      wts_pkg::OP_SET_ROW:     set_row   = in_acc && row_ok;
      wts_pkg::OP_DRAW_NOTE:   draw_start = in_acc;
      wts_pkg::OP_DRAW_RHYTHM: begin
        draw_start     = in_acc;
        draw_is_rhythm = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.start  = draw_start;
    cmd.rhythm = draw_is_rhythm;
    cmd.rnd    = in_rnd;
    if (!cur_ok) begin
      cmd.cols = '0;
    end else if (draw_is_rhythm) begin
      cmd.cols = rhythm_cols;
    end else begin
      cmd.cols = note_cols;
    end
  end

  assign row_ext    = wts_pkg::EXT_W'(in_row);
  assign col_ext    = wts_pkg::EXT_W'(in_col);
  assign cur_ext    = wts_pkg::EXT_W'(current_row);
  assign rcol_ext   = wts_pkg::EXT_W'(rd.col);
  assign weight_ext = 32'(in_weight);
  assign waddr      = {row_ext[ROW_AW-1:0], col_ext[COL_AW-1:0]};
  assign raddr      = {cur_ext[ROW_AW-1:0], rcol_ext[COL_AW-1:0]};
  assign wdata      = weight_ext[WEIGHT_BITS-1:0];
  assign rd_data    = draw_rhythm ? rhythm_q : note_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count  <= wts_pkg::COUNT_RESET;
      note_count   <= wts_pkg::COUNT_RESET;
      rhythm_count <= wts_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (wts_pkg::reg_idx_t'(cfg_index))
        wts_pkg::REG_STATE_COUNT:  state_count  <= cfg_data;
        wts_pkg::REG_NOTE_COUNT:   note_count   <= cfg_data;
        wts_pkg::REG_RHYTHM_COUNT: rhythm_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
    end else if (set_row) begin
      current_row <= in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_start) begin
      draw_rhythm <= draw_is_rhythm;
    end
  end

  wts_weight_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (WEIGHT_BITS)
  ) u_note_mem (
    .clk   (clk),
    .we    (note_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd.en && !draw_rhythm),
    .raddr (raddr),
    .rdata (note_q)
  );

  wts_weight_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (WEIGHT_BITS)
  ) u_rhythm_mem (
    .clk   (clk),
    .we    (rhythm_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd.en && draw_rhythm),
    .raddr (raddr),
    .rdata (rhythm_q)
  );

  wts_draw_engine #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_draw (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .out_free (out_free),
    .rd_data  (rd_data),
    .rd       (rd),
    .res      (res),
    .busy     (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_choice   <= res.choice;
      out_rhythm   <= res.from_rhythm;
      out_fallback <= res.fallback;
    end
  end

  assign m_tdata = {4'b0000, out_choice};
  assign m_tuser = {out_fallback, out_rhythm};

endmodule

>>> tb/weighted_table_sampler_unit_tb.sv
// testbench for weighted_table_sampler_unit: directed and random stream stimulus against a predictor
`timescale 1ns / 100ps

module weighted_table_sampler_unit_tb;

  localparam int TABLE_ROWS   = 16;
  localparam int TABLE_COLS   = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 70;
  localparam logic [wts_pkg::OP_W-1:0] OP_SPARE_FIRST =
    wts_pkg::OP_W'(wts_pkg::OP_DRAW_RHYTHM + 1);
  localparam logic [wts_pkg::OP_W-1:0] OP_SPARE_LAST  = '1;

  localparam int PHASE_ROWS   [6] = '{16, 1, 16, 7, 16, 3};
  localparam int PHASE_NOTES  [6] = '{16, 1, 3, 16, 1, 16};
  localparam int PHASE_RHYTHM [6] = '{16, 1, 16, 5, 16, 2};

  typedef struct packed {
    logic [wts_pkg::CHOICE_W-1:0] choice;
    logic                         from_rhythm;
    logic                         fallback;
  } draw_beat_t;

  class sampler_scoreboard;
    bit [wts_pkg::FIELD_W-1:0] note_tbl   [TABLE_ROWS][TABLE_COLS];
    bit [wts_pkg::FIELD_W-1:0] rhythm_tbl [TABLE_ROWS][TABLE_COLS];
    bit                        note_set   [TABLE_ROWS][TABLE_COLS];
    bit                        rhythm_set [TABLE_ROWS][TABLE_COLS];
    bit [wts_pkg::ROW_W-1:0]   cur_row;
    bit [wts_pkg::COUNT_W-1:0] state_cnt;
    bit [wts_pkg::COUNT_W-1:0] note_cnt;
    bit [wts_pkg::COUNT_W-1:0] rhythm_cnt;
    draw_beat_t                pending_draws[$];
    int                        errors;

    function new();
      cur_row    = '0;
      state_cnt  = wts_pkg::COUNT_RESET;
      note_cnt   = wts_pkg::COUNT_RESET;
      rhythm_cnt = wts_pkg::COUNT_RESET;
      errors     = 0;
    endfunction

    function int rows_live();
      return (state_cnt < TABLE_ROWS) ? state_cnt : TABLE_ROWS;
    endfunction

    function int cols_live(bit rhythm);
      bit [wts_pkg::COUNT_W-1:0] cnt;
      cnt = rhythm ? rhythm_cnt : note_cnt;
      return (cnt < TABLE_COLS) ? cnt : TABLE_COLS;
    endfunction

    function void set_count(wts_pkg::reg_idx_t idx, bit [wts_pkg::COUNT_W-1:0] value);
      case (idx)
        wts_pkg::REG_STATE_COUNT:  state_cnt = value;
        wts_pkg::REG_NOTE_COUNT:   note_cnt = value;
        wts_pkg::REG_RHYTHM_COUNT: rhythm_cnt = value;
        default: ;
      endcase
    endfunction

    function draw_beat_t roulette_pick(bit rhythm, bit [wts_pkg::FIELD_W-1:0] rnd);
      draw_beat_t  r;
      logic [20:0] acc;
      int          n;
      r.choice      = '0;
      r.from_rhythm = rhythm;
      r.fallback    = 1'b1;
      acc           = '0;
      n             = cols_live(rhythm);
      if (cur_row < rows_live()) begin
        for (int i = 0; i < n && r.fallback; i++) begin
          acc += rhythm ? rhythm_tbl[cur_row][i] : note_tbl[cur_row][i];
          if (rnd < acc) begin
            r.choice   = i[wts_pkg::CHOICE_W-1:0];
            r.fallback = 1'b0;
          end
        end
      end
      return r;
    endfunction

    function void apply_item(logic [wts_pkg::OP_W-1:0] op, logic [wts_pkg::ROW_W-1:0] row,
                             logic [wts_pkg::COL_W-1:0] col,
                             logic [wts_pkg::FIELD_W-1:0] w,
                             logic [wts_pkg::FIELD_W-1:0] rnd);
      case (op)
        wts_pkg::OP_WR_NOTE:
          if (row < rows_live() && col < cols_live(1'b0)) begin
            note_tbl[row][col] = w;
            note_set[row][col] = 1'b1;
          end
        wts_pkg::OP_WR_RHYTHM:
          if (row < rows_live() && col < cols_live(1'b1)) begin
            rhythm_tbl[row][col] = w;
            rhythm_set[row][col] = 1'b1;
          end
        wts_pkg::OP_SET_ROW:
          if (row < rows_live()) cur_row = row;
        wts_pkg::OP_DRAW_NOTE:   pending_draws.push_back(roulette_pick(1'b0, rnd));
        wts_pkg::OP_DRAW_RHYTHM: pending_draws.push_back(roulette_pick(1'b1, rnd));
        default: ;
      endcase
    endfunction

    function void check_draw(logic [wts_pkg::CHOICE_W-1:0] choice, logic from_rhythm,
                             logic fallback);
      draw_beat_t exp_beat;
      if (pending_draws.size() == 0) begin
        $error("draw beat with no draw outstanding: choice %0d", choice);
        errors++;
        return;
      end
      exp_beat = pending_draws.pop_front();
      if (choice !== exp_beat.choice) begin
        $error("choice: expected %0d, actual %0d", exp_beat.choice, choice);
        errors++;
      end
      if (from_rhythm !== exp_beat.from_rhythm) begin
        $error("from_rhythm: expected %0d, actual %0d", exp_beat.from_rhythm, from_rhythm);
        errors++;
      end
      if (fallback !== exp_beat.fallback) begin
        $error("fallback: expected %0d, actual %0d", exp_beat.fallback, fallback);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [39:0]                   s_tdata = '0;   // row, column, weight, random_value
  logic [wts_pkg::OP_W-1:0]      s_tuser = '0;   // op
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [7:0]                    m_tdata;        // choice, zero fill
  logic [1:0]                    m_tuser;        // from_rhythm, fallback
  logic                          cfg_we = 1'b0;
  logic [wts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wts_pkg::COUNT_W-1:0]   cfg_data = '0;

  sampler_scoreboard sb = new();
  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  weighted_table_sampler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stall pattern, mode picked anew each time its random countdown runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(8, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_draw(m_tdata[wts_pkg::CHOICE_W-1:0], m_tuser[0], m_tuser[1]);
  end

  function automatic logic [wts_pkg::FIELD_W-1:0] rand16();
    return wts_pkg::FIELD_W'($urandom);
  endfunction

  function automatic logic [wts_pkg::FIELD_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return rand16();
      default: return wts_pkg::FIELD_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [wts_pkg::FIELD_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rand16();
    endcase
  endfunction

  // mostly an index in use, sometimes any index
  function automatic logic [3:0] pick_index(int live);
    if (live > 0 && $urandom_range(0, 4) != 0) return 4'($urandom_range(0, live - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic send_item(input logic [wts_pkg::OP_W-1:0] op,
                           input logic [wts_pkg::ROW_W-1:0] row,
                           input logic [wts_pkg::COL_W-1:0] col,
                           input logic [wts_pkg::FIELD_W-1:0] w,
                           input logic [wts_pkg::FIELD_W-1:0] rnd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {rnd, w, col, row};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.apply_item(op, row, col, w, rnd);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input wts_pkg::reg_idx_t idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wts_pkg::COUNT_W'(value);
    @(posedge clk);
    sb.set_count(idx, wts_pkg::COUNT_W'(value));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int rows, input int notes, input int rhythms);
    drain_results();
    write_count(wts_pkg::REG_STATE_COUNT, rows);
    write_count(wts_pkg::REG_NOTE_COUNT, notes);
    write_count(wts_pkg::REG_RHYTHM_COUNT, rhythms);
  endtask

  // fill any unwritten entry of the current row that the draw may read, then draw
  task automatic draw_from(input bit rhythm, input logic [wts_pkg::FIELD_W-1:0] rnd);
    int n;
    n = sb.cols_live(rhythm);
    if (sb.cur_row < sb.rows_live()) begin
      for (int c = 0; c < n; c++) begin
        if (!(rhythm ? sb.rhythm_set[sb.cur_row][c] : sb.note_set[sb.cur_row][c]))
          send_item(rhythm ? wts_pkg::OP_WR_RHYTHM : wts_pkg::OP_WR_NOTE, sb.cur_row,
                    wts_pkg::COL_W'(c), rand_weight(), rand16());
      end
    end
    send_item(rhythm ? wts_pkg::OP_DRAW_RHYTHM : wts_pkg::OP_DRAW_NOTE, 4'($urandom),
              4'($urandom), rand16(), rnd);
  endtask

  task automatic random_item();
    int  k;
    bit  rhythm;
    k      = $urandom_range(0, 99);
    rhythm = 1'($urandom_range(0, 1));
    if (k < 40) begin
      draw_from(rhythm, rand_level());
    end else if (k < 62) begin
      send_item(rhythm ? wts_pkg::OP_WR_RHYTHM : wts_pkg::OP_WR_NOTE,
                pick_index(sb.rows_live()), pick_index(sb.cols_live(rhythm)),
                rand_weight(), rand16());
    end else if (k < 77) begin
      send_item(rhythm ? wts_pkg::OP_WR_RHYTHM : wts_pkg::OP_WR_NOTE, sb.cur_row,
                pick_index(sb.cols_live(rhythm)), rand_weight(), rand16());
    end else if (k < 94) begin
      send_item(wts_pkg::OP_SET_ROW, pick_index(sb.rows_live()), 4'($urandom), rand16(),
                rand16());
    end else begin
      send_item(wts_pkg::OP_WR_NOTE, 4'($urandom), 4'($urandom), rand16(), rand16());
      send_item(wts_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                4'($urandom), 4'($urandom), rand16(), rand16());
    end
  endtask

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(2, 2, 2);
    send_item(wts_pkg::OP_WR_NOTE, 4'd0, 4'd0, 16'h0000, rand16());
    send_item(wts_pkg::OP_WR_NOTE, 4'd0, 4'd1, 16'hFFFF, rand16());
    send_item(wts_pkg::OP_WR_RHYTHM, 4'd0, 4'd0, 16'hFFFF, rand16());
    send_item(wts_pkg::OP_WR_RHYTHM, 4'd0, 4'd1, 16'h0001, rand16());
    send_item(wts_pkg::OP_DRAW_NOTE, 4'd0, 4'd0, rand16(), 16'h0000);
    send_item(wts_pkg::OP_DRAW_NOTE, 4'd0, 4'd0, rand16(), 16'hFFFF);
    send_item(wts_pkg::OP_DRAW_RHYTHM, 4'd0, 4'd0, rand16(), 16'hFFFE);
    send_item(wts_pkg::OP_DRAW_RHYTHM, 4'd0, 4'd0, rand16(), 16'hFFFF);
    send_item(wts_pkg::OP_WR_NOTE, 4'd15, 4'd0, 16'h1234, rand16());
    send_item(wts_pkg::OP_WR_RHYTHM, 4'd1, 4'd15, 16'h4321, rand16());
    send_item(wts_pkg::OP_SET_ROW, 4'd15, 4'd0, rand16(), rand16());
    send_item(wts_pkg::OP_DRAW_NOTE, 4'd0, 4'd0, rand16(), 16'h0000);
    send_item(wts_pkg::OP_SET_ROW, 4'd1, 4'd0, rand16(), rand16());
    send_item(wts_pkg::OP_WR_NOTE, 4'd1, 4'd0, 16'h8000, rand16());
    send_item(wts_pkg::OP_WR_NOTE, 4'd1, 4'd1, 16'h7FFF, rand16());
    send_item(wts_pkg::OP_WR_RHYTHM, 4'd1, 4'd0, 16'h0000, rand16());
    send_item(wts_pkg::OP_WR_RHYTHM, 4'd1, 4'd1, 16'h0000, rand16());
    send_item(wts_pkg::OP_DRAW_NOTE, 4'd0, 4'd0, rand16(), 16'h7FFF);
    send_item(wts_pkg::OP_DRAW_RHYTHM, 4'd0, 4'd0, rand16(), 16'h0000);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_item(wts_pkg::OP_W'(op), 4'($urandom), 4'($urandom), rand16(), rand16());

    // current row falls outside the rows in use
    configure(1, 2, 2);
    send_item(wts_pkg::OP_DRAW_NOTE, 4'd0, 4'd0, rand16(), 16'h0000);
    // zero note count
    configure(2, 0, 2);
    send_item(wts_pkg::OP_DRAW_NOTE, 4'd0, 4'd0, rand16(), 16'h0000);
    send_item(wts_pkg::OP_DRAW_RHYTHM, 4'd0, 4'd0, rand16(), 16'h0000);
    // zero state count
    configure(0, 2, 2);
    send_item(wts_pkg::OP_WR_NOTE, 4'd0, 4'd0, 16'hFFFF, rand16());
    send_item(wts_pkg::OP_SET_ROW, 4'd0, 4'd0, rand16(), rand16());
    send_item(wts_pkg::OP_DRAW_RHYTHM, 4'd0, 4'd0, rand16(), 16'h0000);

    for (int p = 0; p < 8; p++) begin
      if (p < 6)
        configure(PHASE_ROWS[p], PHASE_NOTES[p], PHASE_RHYTHM[p]);
      else
        configure($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
        if (p == 3 && i == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.pending_draws.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> weighted_table_sampler_unit.f
rtl/core/wts_pkg.sv
rtl/core/wts_weight_mem.sv
rtl/core/wts_draw_engine.sv
rtl/core/weighted_table_sampler_unit.sv
tb/weighted_table_sampler_unit_tb.sv
